// ===== design/rrps_pkg.sv =====
// rrps_pkg: shared types and constants for the round-robin process scheduler.
// No dependencies.
`timescale 1ns / 1ps
package rrps_pkg;
	localparam int MaxProcsDef = 16;
	localparam logic [7:0] QuantumRst = 8'd2;

	localparam logic [2:0] KIND_REPORT  = 3'd0;
	localparam logic [2:0] KIND_LOAD_OK = 3'd1;
	localparam logic [2:0] KIND_DUP     = 3'd2;
	localparam logic [2:0] KIND_ZERO    = 3'd3;
	localparam logic [2:0] KIND_FULL    = 3'd4;
	localparam logic [2:0] KIND_DONE    = 3'd5;
	localparam logic [2:0] KIND_LATE    = 3'd6;

	localparam logic [1:0] ST_READY   = 2'd0;
	localparam logic [1:0] ST_RUNNING = 2'd1;
	localparam logic [1:0] ST_TERM    = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE, S_DUP_RD, S_DUP_CHK, S_INS_RD, S_INS_TAB, S_INS_CHK, S_LOAD_WR,
		S_RUN_RD, S_RUN_WR, S_REP_RD, S_REP_TAB, S_REP_OUT, S_RESP
	} state_t;

	// process table entry
	typedef struct packed {
		logic [15:0] id;
		logic [15:0] work;
		logic [15:0] prog;
		logic [1:0]  status;
	} entry_t;
endpackage

// ===== design/round_robin_process_scheduler.sv =====
// round_robin_process_scheduler: top level, sequencer around three memories
// (process table, ID-sorted order, ready queue). Uses rrps_pkg, rrps_ram.
//
//  channel | signals                                     | dir
//  in      | in_valid, in_stall, cmd, proc_id, proc_work | requests in
//  out     | out_valid, out_stall, kind .. last          | results out
//  cfg     | cfg_we, cfg_wdata (quantum)                 | write only
//
// Load: accept, duplicate scan over every loaded table entry, insertion shift
// in the ID order memory (each entry with a larger ID moves up one place), the
// write of the new entry, then the status result.
// Tick: accept, dispatch of the queue head (if any is queued), then one report
// per loaded process in ID order. An all-done tick gives only the DONE status.
// arst_n clears all control; memory contents are never used before being written.
// A stalled result holds its register; the sequencer waits while it is stalled.
`timescale 1ns / 1ps
module round_robin_process_scheduler #(
	parameter int MaxProcs = rrps_pkg::MaxProcsDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        cmd,
	input  logic [15:0] proc_id,
	input  logic [15:0] proc_work,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  kind,
	output logic [31:0] tick_number,
	output logic [15:0] report_id,
	output logic [1:0]  report_state,
	output logic [15:0] report_progress,
	output logic        last
);
	localparam int AW = (MaxProcs > 1) ? $clog2(MaxProcs) : 1;
	localparam int CW = $clog2(MaxProcs + 1);
	localparam int EW = $bits(rrps_pkg::entry_t);
	localparam logic [CW-1:0] MaxCnt = CW'(MaxProcs);

	rrps_pkg::state_t state_q, state_d;

	logic [7:0]    quantum_q;
	logic [AW-1:0] head_q, head_d;
	logic [CW-1:0] fill_q, fill_d, loaded_q, loaded_d, done_q, done_d;
	logic [31:0]   tick_q, tick_d;
	logic          started_q, started_d;
	logic [CW-1:0] i_q, i_d;            // scan / shift / report index
	logic [15:0]   id_q, work_q;        // latched request
	logic [2:0]    kind_q, kind_d;      // status response kind
	logic [AW-1:0] run_q, run_d;        // dispatched slot
	logic          requeue_q, requeue_d;
	logic [AW-1:0] ord_q, ord_d;        // latched id order entry
	rrps_pkg::entry_t run_ent_q, run_ent_d; // dispatched entry as written back

	// table memory
	logic           t_we;
	logic [AW-1:0]  t_wa, t_ra;
	rrps_pkg::entry_t t_wd, t_rd;
	// id order memory
	logic           o_we;
	logic [AW-1:0]  o_wa, o_ra, o_rd, o_wd;
	// ready queue memory
	logic           f_we;
	logic [AW-1:0]  f_wa, f_ra, f_rd, f_wd;

	rrps_ram #(.Width(EW), .Depth(MaxProcs)) u_tab (
		.clk(clk), .we(t_we), .waddr(t_wa), .wdata(t_wd), .raddr(t_ra), .rdata(t_rd));
	rrps_ram #(.Width(AW), .Depth(MaxProcs)) u_ord (
		.clk(clk), .we(o_we), .waddr(o_wa), .wdata(o_wd), .raddr(o_ra), .rdata(o_rd));
	rrps_ram #(.Width(AW), .Depth(MaxProcs)) u_fifo (
		.clk(clk), .we(f_we), .waddr(f_wa), .wdata(f_wd), .raddr(f_ra), .rdata(f_rd));

	// output register
	logic        ov_q;
	logic [2:0]  ok_q;
	logic [31:0] otick_q;
	logic [15:0] oid_q, oprog_q;
	logic [1:0]  ost_q;
	logic        olast_q;
	logic        o_load;
	logic [2:0]  o_kind;
	logic [15:0] o_id, o_prog;
	logic [1:0]  o_st;
	logic        o_last;
	logic        o_free;

	assign o_free = !ov_q || !out_stall;
	assign in_stall = (state_q != rrps_pkg::S_IDLE);

	function automatic logic [AW-1:0] wrap(input logic [CW:0] v);
		logic [CW:0] r;
		r = (v >= (CW+1)'(MaxProcs)) ? v - (CW+1)'(MaxProcs) : v;
		return r[AW-1:0];
	endfunction

	logic [15:0] rem, runamt, newprog;
	always_comb begin
		rem = t_rd.work - t_rd.prog;
		runamt = ({8'd0, quantum_q} < rem) ? {8'd0, quantum_q} : rem;
		newprog = t_rd.prog + runamt;
	end

	always_comb begin
		state_d = state_q;
		head_d = head_q; fill_d = fill_q; loaded_d = loaded_q; done_d = done_q;
		tick_d = tick_q; started_d = started_q; i_d = i_q; kind_d = kind_q;
		run_d = run_q; requeue_d = requeue_q; ord_d = ord_q; run_ent_d = run_ent_q;
		t_we = 1'b0; t_wa = '0; t_wd = '0; t_ra = '0;
		o_we = 1'b0; o_wa = '0; o_wd = '0; o_ra = '0;
		f_we = 1'b0; f_wa = '0; f_wd = '0; f_ra = head_q;
		o_load = 1'b0; o_kind = rrps_pkg::KIND_REPORT;
		o_id = '0; o_prog = '0; o_st = '0; o_last = 1'b1;
		unique case (state_q)
			rrps_pkg::S_IDLE: begin
				// queue head is read here so it is ready for dispatch
				if (in_valid) begin
					i_d = '0;
					requeue_d = 1'b0;
					if (cmd) begin
						started_d = 1'b1;
						if (done_q >= loaded_q) begin
							kind_d = rrps_pkg::KIND_DONE;
							state_d = rrps_pkg::S_RESP;
						end else begin
							tick_d = tick_q + 32'd1;
							kind_d = rrps_pkg::KIND_REPORT;
							state_d = (fill_q != '0) ? rrps_pkg::S_RUN_RD
								: rrps_pkg::S_REP_RD;
						end
					end else if (started_q) begin
						kind_d = rrps_pkg::KIND_LATE;
						state_d = rrps_pkg::S_RESP;
					end else if (proc_work == '0) begin
						kind_d = rrps_pkg::KIND_ZERO;
						state_d = rrps_pkg::S_RESP;
					end else begin
						kind_d = rrps_pkg::KIND_LOAD_OK;
						state_d = rrps_pkg::S_DUP_RD;
					end
				end
			end
			rrps_pkg::S_DUP_RD: begin
				if (i_q >= loaded_q) begin
					if (loaded_q >= MaxCnt) begin
						kind_d = rrps_pkg::KIND_FULL;
						state_d = rrps_pkg::S_RESP;
					end else begin
						i_d = loaded_q;
						state_d = rrps_pkg::S_INS_RD;
					end
				end else begin
					t_ra = i_q[AW-1:0];
					state_d = rrps_pkg::S_DUP_CHK;
				end
			end
			rrps_pkg::S_DUP_CHK: begin
				if (t_rd.id == id_q) begin
					kind_d = rrps_pkg::KIND_DUP;
					state_d = rrps_pkg::S_RESP;
				end else begin
					i_d = i_q + CW'(1);
					state_d = rrps_pkg::S_DUP_RD;
				end
			end
			rrps_pkg::S_INS_RD: begin
				// fetch id_order[i-1], then its table ID
				if (i_q == '0) state_d = rrps_pkg::S_LOAD_WR;
				else begin
					o_ra = AW'(i_q - CW'(1));
					state_d = rrps_pkg::S_INS_TAB;
				end
			end
			rrps_pkg::S_INS_TAB: begin
				t_ra = o_rd;
				ord_d = o_rd;
				state_d = rrps_pkg::S_INS_CHK;
			end
			rrps_pkg::S_INS_CHK: begin
				// larger ID moves up one place
				if (t_rd.id > id_q) begin
					o_we = 1'b1; o_wa = i_q[AW-1:0]; o_wd = ord_q;
					i_d = i_q - CW'(1);
					state_d = rrps_pkg::S_INS_RD;
				end else state_d = rrps_pkg::S_LOAD_WR;
			end
			rrps_pkg::S_LOAD_WR: begin
				t_we = 1'b1; t_wa = loaded_q[AW-1:0];
				t_wd = '{id: id_q, work: work_q, prog: 16'd0, status: rrps_pkg::ST_READY};
				o_we = 1'b1; o_wa = i_q[AW-1:0]; o_wd = loaded_q[AW-1:0];
				f_we = 1'b1; f_wa = wrap({1'b0, CW'(head_q)} + {1'b0, fill_q});
				f_wd = loaded_q[AW-1:0];
				fill_d = fill_q + CW'(1);
				loaded_d = loaded_q + CW'(1);
				state_d = rrps_pkg::S_RESP;
			end
			rrps_pkg::S_RUN_RD: begin
				// f_rd now holds queue head; fetch table entry
				t_ra = f_rd;
				run_d = f_rd;
				head_d = wrap({1'b0, CW'(head_q)} + (CW+1)'(1));
				fill_d = fill_q - CW'(1);
				state_d = rrps_pkg::S_RUN_WR;
			end
			rrps_pkg::S_RUN_WR: begin
				t_we = 1'b1; t_wa = run_q;
				t_wd = t_rd;
				t_wd.prog = newprog;
				if (newprog >= t_rd.work) begin
					t_wd.status = rrps_pkg::ST_TERM;
					done_d = done_q + CW'(1);
				end else begin
					t_wd.status = rrps_pkg::ST_RUNNING;
					requeue_d = 1'b1;
				end
				run_ent_d = t_wd;
				state_d = rrps_pkg::S_REP_RD;
			end
			rrps_pkg::S_REP_RD: begin
				o_ra = i_q[AW-1:0];
				state_d = rrps_pkg::S_REP_TAB;
			end
			rrps_pkg::S_REP_TAB: begin
				t_ra = o_rd;
				ord_d = o_rd;
				state_d = rrps_pkg::S_REP_OUT;
			end
			rrps_pkg::S_REP_OUT: begin
				// address held so t_rd stays valid while the output waits
				t_ra = ord_q;
				if (o_free) begin
					o_load = 1'b1;
					o_kind = rrps_pkg::KIND_REPORT;
					o_id = t_rd.id; o_st = t_rd.status; o_prog = t_rd.prog;
					o_last = (i_q + CW'(1) == loaded_q);
					if (o_last) begin
						// running process goes back to the tail as Ready
						if (requeue_q) begin
							t_we = 1'b1; t_wa = run_q; t_wd = run_ent_q;
							t_wd.status = rrps_pkg::ST_READY;
							f_we = 1'b1; f_wa = wrap({1'b0, CW'(head_q)} + {1'b0, fill_q});
							f_wd = run_q;
							fill_d = fill_q + CW'(1);
							requeue_d = 1'b0;
						end
						state_d = rrps_pkg::S_IDLE;
					end else begin
						i_d = i_q + CW'(1);
						state_d = rrps_pkg::S_REP_RD;
					end
				end
			end
			rrps_pkg::S_RESP: begin
				if (o_free) begin
					o_load = 1'b1; o_kind = kind_q; o_last = 1'b1;
					state_d = rrps_pkg::S_IDLE;
				end
			end
			default: state_d = rrps_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rrps_pkg::S_IDLE;
			quantum_q <= rrps_pkg::QuantumRst;
			head_q <= '0; fill_q <= '0; loaded_q <= '0; done_q <= '0;
			tick_q <= '0; started_q <= 1'b0; i_q <= '0; kind_q <= '0;
			run_q <= '0; requeue_q <= 1'b0; ov_q <= 1'b0;
			ord_q <= '0; run_ent_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) quantum_q <= cfg_wdata;
			head_q <= head_d; fill_q <= fill_d; loaded_q <= loaded_d;
			done_q <= done_d; tick_q <= tick_d; started_q <= started_d;
			i_q <= i_d; kind_q <= kind_d; run_q <= run_d; requeue_q <= requeue_d;
			ord_q <= ord_d; run_ent_q <= run_ent_d;
			if (o_load) ov_q <= 1'b1;
			else if (!out_stall) ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == rrps_pkg::S_IDLE && in_valid) begin
			id_q <= proc_id; work_q <= proc_work;
		end
		if (o_load) begin
			ok_q <= o_kind; otick_q <= tick_q; oid_q <= o_id; ost_q <= o_st;
			oprog_q <= o_prog; olast_q <= o_last;
		end
	end

	assign out_valid = ov_q;
	assign kind = ok_q;
	assign tick_number = otick_q;
	assign report_id = oid_q;
	assign report_state = ost_q;
	assign report_progress = oprog_q;
	assign last = olast_q;

	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= loaded_q) else $error("queue fill exceeds loaded count");
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		done_q <= loaded_q) else $error("done count exceeds loaded count");
	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		started_q |=> loaded_q == $past(loaded_q)) else $error("load after start");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(kind) && $stable(tick_number)
		&& $stable(report_id) && $stable(report_progress))
		else $error("stalled result changed");
endmodule

// ===== design/rrps_ram.sv =====
// rrps_ram: generic single-port-write, single-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module rrps_ram #(
	parameter int Width = 8,
	parameter int Depth = 16,
	parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AddrW-1:0] waddr,
	input  logic [Width-1:0] wdata,
	input  logic [AddrW-1:0] raddr,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
